[rtl/cdd_pkg.sv]
// shared types and constants of the concatenating dictionary decoder
package cdd_pkg;
    localparam int FIRST_FREE  = 256;
    localparam int START_WIDTH = 9;
    localparam int SEED_ENTRY  = 255;
    localparam int OUT_W       = 16;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_ENDED   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_RUN   = 2'd1,
        PH_ENDED = 2'd2
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LEAF = 5'b00100,
        S_POP  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;
endpackage

[rtl/concat_dictionary_decoder_top.sv]
// top level of the concatenating dictionary decoder
//
// channel | dir | tdata                          | tuser   | tlast
// s_axis  | in  | [7:0] data_byte                | action  | last_byte
// m_axis  | out | [7:0] out_byte [8] out_valid   | -       | -
//         |     | [9] more_pending [12:10] status |         |
//
// a push or an empty pull is answered from idle; a pull passes a read state per
// dictionary step down the left spine, a leaf state, a pop state when the walk
// stack is not empty, and a done state. each step reads two dictionary addresses.
// reset is synchronous and clears control state only; memories are not cleared.
// a new request is taken while a result waits, as long as the output register
// frees up in the same cycle; a stalled output holds the finishing walk.
module concat_dictionary_decoder_top
    import cdd_pkg::*;
#(
    parameter int MAX_CODE_BITS = 14,
    parameter int STACK_DEPTH   = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,  // [7:0] data_byte
    input  logic             i_s_axis_tuser,  // action
    input  logic             i_s_axis_tlast,  // last_byte
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata   // out_byte, out_valid, more_pending, status
);
    localparam int AW   = MAX_CODE_BITS;
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int BW   = AW + 8;
    localparam int CNTW = $clog2(BW + 1);
    localparam int CWW  = $clog2(AW + 1);
    localparam int NW   = AW + 1;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [NW-1:0]   r_nfc, n_nfc;
    logic [CWW-1:0]  r_cw, n_cw;
    logic [BW-1:0]   r_buf, n_buf;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [AW-1:0]   r_wcode, n_wcode;
    logic [SW:0]     r_top, n_top;
    logic            r_busy, n_busy;
    logic [AW-1:0]   r_c, n_c;
    logic [7:0]      r_ob, n_ob;
    logic            r_mvalid, n_mvalid;
    logic [OUT_W-1:0] r_mdata, n_mdata;

    logic            dict_we;
    logic [AW-1:0]   dict_waddr, dict_wdata, dict_ra, dict_rb, dict_qa, dict_qb;
    logic            stk_we;
    logic [SW-1:0]   stk_waddr, stk_raddr;
    logic [AW-1:0]   stk_wdata, stk_q;

    logic            s_acc, slot_free;
    logic [BW-1:0]   t_buf, code_mask;
    logic [CNTW-1:0] t_cnt;
    logic [AW-1:0]   t_code;
    logic [NW-1:0]   code_ext;
    t_status         p_st;

    cdd_dict_ram #(.AW(AW)) u_dict (
        .i_clk    (i_clk),
        .i_we     (dict_we),
        .i_waddr  (dict_waddr),
        .i_wdata  (dict_wdata),
        .i_raddr_a(dict_ra),
        .i_raddr_b(dict_rb),
        .o_rdata_a(dict_qa),
        .o_rdata_b(dict_qb)
    );

    cdd_stack_ram #(.DEPTH(STACK_DEPTH), .DW(AW)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_q)
    );

    assign slot_free       = !r_mvalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && slot_free;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;

    // bit unpacking of a pushed byte
    assign t_buf     = r_buf | (BW'(i_s_axis_tdata) << r_cnt);
    assign t_cnt     = r_cnt + CNTW'(8);
    assign code_mask = ~({BW{1'b1}} << r_cw);
    assign t_code    = AW'(t_buf & code_mask);
    assign code_ext  = {1'b0, t_code};

    // control, dictionary update and walk
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_nfc    = r_nfc;
        n_cw     = r_cw;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_wcode  = r_wcode;
        n_top    = r_top;
        n_busy   = r_busy;
        n_c      = r_c;
        n_ob     = r_ob;
        n_mvalid = r_mvalid && !i_m_axis_tready;
        n_mdata  = r_mdata;
        p_st       = ST_OK;
        dict_we    = 1'b0;
        dict_waddr = r_nfc[AW-1:0];
        dict_wdata = t_code;
        dict_ra    = r_c;
        dict_rb    = r_c - AW'(1);
        stk_we     = 1'b0;
        stk_waddr  = r_top[SW-1:0];
        stk_wdata  = dict_qa;
        stk_raddr  = r_top[SW-1:0] - SW'(1);
        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_axis_tuser) begin
                    if (!r_busy) begin
                        n_mvalid = 1'b1;
                        n_mdata  = OUT_W'({ST_EMPTY, 1'b0, 1'b0, 8'd0});
                    end else begin
                        n_c   = r_wcode;
                        dict_ra = r_wcode;
                        dict_rb = r_wcode - AW'(1);
                        n_state = (r_wcode >= AW'(FIRST_FREE)) ? S_READ : S_LEAF;
                    end
                end else if (s_acc) begin
                    if (r_busy) begin
                        p_st = ST_BUSY;
                    end else begin
                        if (r_phase == PH_ENDED) begin
                            p_st = ST_ENDED;
                        end else begin
                            n_buf = t_buf;
                            n_cnt = t_cnt;
                            if (t_cnt >= CNTW'(r_cw)) begin
                                n_buf = t_buf >> r_cw;
                                n_cnt = t_cnt - CNTW'(r_cw);
                                if (code_ext == r_nfc) begin
                                    n_nfc   = NW'(FIRST_FREE);
                                    n_cw    = CWW'(START_WIDTH);
                                    n_phase = PH_FIRST;
                                end else if (code_ext > r_nfc) begin
                                    n_phase = PH_ENDED;
                                    p_st    = ST_ENDED;
                                end else begin
                                    if (r_phase == PH_FIRST) begin
                                        dict_we    = 1'b1;
                                        dict_waddr = AW'(SEED_ENTRY);
                                        n_phase    = PH_RUN;
                                    end else if (r_nfc[AW]) begin
                                        p_st = ST_OVERFLOW;
                                    end else begin
                                        dict_we = 1'b1;
                                        n_nfc   = r_nfc + NW'(1);
                                        if (r_cw < CWW'(AW) &&
                                            (r_nfc + NW'(1)) == (NW'(1) << r_cw)) begin
                                            n_cw = r_cw + CWW'(1);
                                        end
                                    end
                                    n_wcode = t_code;
                                    n_top   = '0;
                                    n_busy  = 1'b1;
                                end
                            end
                        end
                        if (i_s_axis_tlast) begin
                            n_buf   = '0;
                            n_cnt   = '0;
                            n_nfc   = NW'(FIRST_FREE);
                            n_cw    = CWW'(START_WIDTH);
                            n_phase = PH_FIRST;
                        end
                    end
                    n_mvalid = 1'b1;
                    n_mdata  = OUT_W'({p_st, n_busy, 1'b0, 8'd0});
                end
            end
            S_READ: begin
                // push the right half, follow the left half
                if (r_top < (SW+1)'(STACK_DEPTH)) begin
                    stk_we = 1'b1;
                    n_top  = r_top + (SW+1)'(1);
                end
                n_c     = dict_qb;
                dict_ra = dict_qb;
                dict_rb = dict_qb - AW'(1);
                n_state = (dict_qb >= AW'(FIRST_FREE)) ? S_READ : S_LEAF;
            end
            S_LEAF: begin
                n_ob = r_c[7:0];
                if (r_top != '0) begin
                    n_top   = r_top - (SW+1)'(1);
                    n_state = S_POP;
                end else begin
                    n_busy  = 1'b0;
                    n_wcode = '0;
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                n_wcode = stk_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_mvalid = 1'b1;
                    n_mdata  = OUT_W'({ST_OK, r_busy, 1'b1, r_ob});
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FIRST;
            r_nfc    <= NW'(FIRST_FREE);
            r_cw     <= CWW'(START_WIDTH);
            r_buf    <= '0;
            r_cnt    <= '0;
            r_wcode  <= '0;
            r_top    <= '0;
            r_busy   <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_nfc    <= n_nfc;
            r_cw     <= n_cw;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_wcode  <= n_wcode;
            r_top    <= n_top;
            r_busy   <= n_busy;
            r_mvalid <= n_mvalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_ob    <= n_ob;
        r_mdata <= n_mdata;
    end
endmodule

[rtl/cdd_dict_ram.sv]
// dictionary memory, one write port and two registered read ports
module cdd_dict_ram #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [AW-1:0] o_rdata_a,
    output logic [AW-1:0] o_rdata_b
);
    logic [AW-1:0] r_mem [2**AW];

    // write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

[rtl/cdd_stack_ram.sv]
// walk stack memory, one write port and one registered read port
module cdd_stack_ram #(
    parameter int DEPTH = 16384,
    parameter int DW    = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    // write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/cdd_checker.sv]
// port checker of the decoder and its bind
module cdd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // status code in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[12:10] <= 3'd4)
        else $error("status out of range");

    // a delivered byte carries ok status
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[8] |-> o_m_axis_tdata[12:10] == 3'd0)
        else $error("byte with bad status");

    // no byte means zero byte
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[8] |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("nonzero byte without valid");
endmodule

bind concat_dictionary_decoder_top cdd_checker u_cdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
